// File: sv/fsst_pkg.sv
// shared widths and codes for the fibonacci search table unit
package fsst_pkg;

    localparam int TABLE_DEPTH = 16;  // key table entries, fixed by the 4-bit entry index
    localparam int KEY_W   = 32;  // stored and target key
    localparam int IDX_W   = 4;   // entry index on the ports
    localparam int CNT_W   = 5;   // entry count register, probe and base
    localparam int FIB_W   = 6;   // fibonacci terms, up to 21 for a count of 16 (counts saturate to the depth)
    localparam int PROBE_W = 7;   // base + f2 before clamping

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // register select, paddr[2]
    localparam logic REG_ENTRIES = 1'b0;

endpackage

// File: sv/fsst_key_ram.sv
// key table storage: one write port, one registered read port
module fsst_key_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [fsst_pkg::KEY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [fsst_pkg::KEY_W-1:0] rd_data
);

    logic [fsst_pkg::KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/fibonacci_search_sorted_table_unit.sv
// Fibonacci search over a sorted table of signed 32-bit keys
//
// Input beats carry a request: s_tuser selects write or search, s_tdata holds
// the entry index and the key. A write stores the key in the table at the
// accepting edge and gives no result beat. A search runs a Fibonacci search
// over the first entries_in_use entries (APB register at byte address 0,
// saturated to the table depth) and gives one result beat: m_tuser = found,
// m_tdata = matching position, 0 when not found.
// A write is stored at the accepting edge. A search is accepted, grows the
// Fibonacci terms (G steps until the term reaches the count), then probes:
// each probe sends the address to the table memory, then compares with the
// registered read data. A final check (ST_FINAL, then ST_FCMP when the entry
// past the base is read) and a load of the output register follow. A search of 16
// entries takes 6 grow steps and up to 6 probes, fewer on an early hit. The single
// read port of the table sets the probe pace. One item is worked on at a time; s_tready
// is high only between items, also while a result beat waits in the output
// register. A stalled result holds the engine in its last state until the
// output register frees up. Reset clears the count register and all control
// state; table contents are undefined until written.
module fibonacci_search_sorted_table_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] entry_index, [35:4] key_value, rest zero
    input  logic        s_tuser,   // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] position, rest zero
    output logic        m_tuser,   // [0] found

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TABLE_DEPTH = fsst_pkg::TABLE_DEPTH;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int KEY_W = fsst_pkg::KEY_W;
    localparam int IDX_W = fsst_pkg::IDX_W;
    localparam int CNT_W = fsst_pkg::CNT_W;
    localparam int FIB_W = fsst_pkg::FIB_W;
    localparam int PW    = fsst_pkg::PROBE_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_GROW, ST_PROBE, ST_CMP, ST_FINAL, ST_FCMP, ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cfg_entries_reg;
    logic [KEY_W-1:0]   target_reg, target_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [FIB_W-1:0]   f_reg, f_next, f1_reg, f1_next, f2_reg, f2_next;
    logic [CNT_W-1:0]   base1_reg, base1_next;  // offset + 1
    logic [CNT_W-1:0]   probe_reg, probe_next;
    logic               res_found_reg, res_found_next;
    logic [IDX_W-1:0]   res_pos_reg, res_pos_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_found_reg, m_found_next;
    logic [IDX_W-1:0]   m_pos_reg, m_pos_next;

    logic [IDX_W-1:0]   s_entry_index;
    logic [KEY_W-1:0]   s_key_value;
    logic               in_beat;
    logic [CNT_W-1:0]   n_sat;
    logic [PW-1:0]      probe_sum, probe_raw, probe_last, probe_c;
    logic [FIB_W-1:0]   f_after;
    logic               key_eq, key_lt;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    assign s_entry_index = s_tdata[IDX_W-1:0];
    assign s_key_value   = s_tdata[IDX_W +: KEY_W];
    assign s_tready      = (state_reg == ST_IDLE);
    assign in_beat       = s_tvalid && s_tready;

    assign ram_we    = in_beat && (s_tuser == fsst_pkg::REQ_WRITE)
                       && (int'(s_entry_index) < TABLE_DEPTH);
    assign ram_waddr = AW'(s_entry_index);

    fsst_key_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_key_value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fsst_pkg::REG_ENTRIES) ? 32'(cfg_entries_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_entries_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == fsst_pkg::REG_ENTRIES) begin
            cfg_entries_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign n_sat = (int'(cfg_entries_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : cfg_entries_reg;

    // probe = min(max(offset + f2, 0), n - 1)
    assign probe_sum  = PW'(base1_reg) + PW'(f2_reg);
    assign probe_raw  = (probe_sum == '0) ? '0 : probe_sum - PW'(1);
    assign probe_last = PW'(n_reg) - PW'(1);
    assign probe_c    = (probe_raw > probe_last) ? probe_last : probe_raw;

    assign key_eq = (ram_rdata == target_reg);
    assign key_lt = ($signed(ram_rdata) < $signed(target_reg));

    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        n_next         = n_reg;
        f_next         = f_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        base1_next     = base1_reg;
        probe_next     = probe_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        f_after        = f_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat && s_tuser == fsst_pkg::REQ_SEARCH) begin
                    target_next = s_key_value;
                    n_next      = n_sat;
                    f2_next     = FIB_W'(0);
                    f1_next     = FIB_W'(1);
                    f_next      = FIB_W'(1);
                    base1_next  = '0;
                    if (n_sat == '0) begin
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_GROW;
                    end
                end
            end
            ST_GROW: begin
                if (f_reg < FIB_W'(n_reg)) begin
                    f2_next = f1_reg;
                    f1_next = f_reg;
                    f_next  = f_reg + f1_reg;
                end else if (f_reg > FIB_W'(1)) begin
                    state_next = ST_PROBE;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_PROBE: begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(probe_c);
                probe_next = CNT_W'(probe_c);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (key_eq) begin
                    res_found_next = 1'b1;
                    res_pos_next   = IDX_W'(probe_reg);
                    state_next     = ST_DONE;
                end else begin
                    if (key_lt) begin
                        // keep the upper part
                        f_after    = f1_reg;
                        f1_next    = f2_reg;
                        f2_next    = f1_reg - f2_reg;
                        base1_next = probe_reg + CNT_W'(1);
                    end else begin
                        f_after = f2_reg;
                        f1_next = f1_reg - f2_reg;
                        f2_next = f2_reg - (f1_reg - f2_reg);
                    end
                    f_next     = f_after;
                    state_next = (f_after > FIB_W'(1)) ? ST_PROBE : ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (f1_reg != '0 && base1_reg < n_reg) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(base1_reg);
                    state_next = ST_FCMP;
                end else begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_FCMP: begin
                res_found_next = key_eq;
                res_pos_next   = key_eq ? IDX_W'(base1_reg) : '0;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = res_found_reg;
                    m_pos_next    = res_pos_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        target_reg    <= target_next;
        n_reg         <= n_next;
        f_reg         <= f_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        base1_reg     <= base1_next;
        probe_reg     <= probe_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(8 - IDX_W){1'b0}}, m_pos_reg};

    // a miss reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_found_reg |-> m_pos_reg == '0)
        else $error("miss with nonzero position");

    // probes stay inside the searched range
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> probe_reg < n_reg)
        else $error("probe beyond entry count");

    a_final_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FCMP |-> base1_reg < n_reg)
        else $error("final check beyond entry count");

    // terms stay a fibonacci triple while probing
    a_fib_triple: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE || state_reg == ST_CMP |-> f_reg == f1_reg + f2_reg)
        else $error("fibonacci terms out of step");

    // an accepted search always leaves idle
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && s_tuser == fsst_pkg::REQ_SEARCH |=> state_reg != ST_IDLE)
        else $error("search dropped");

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the fibonacci search table unit
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH   = fsst_pkg::TABLE_DEPTH;
    localparam int KEY_W         = fsst_pkg::KEY_W;
    localparam int IDX_W         = fsst_pkg::IDX_W;
    localparam int CNT_W         = fsst_pkg::CNT_W;
    localparam int ITEM_TARGET   = 450;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 300000;

    typedef struct packed {
        logic [KEY_W-1:0] target;
        logic             found;
        logic [IDX_W-1:0] position;
    } search_result_t;

    // keeps an image of the key table and the count, predicts each search
    class search_scoreboard;
        logic [KEY_W-1:0] key_table [TABLE_DEPTH];
        logic [CNT_W-1:0] entries_in_use;
        search_result_t   pending [$];
        int unsigned      errors, searches, hits, writes;

        function new();
            foreach (key_table[i]) key_table[i] = '0;
            entries_in_use = '0;
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 10) $display("ERROR: %s", msg);
        endfunction

        function search_result_t fib_search(logic [KEY_W-1:0] target);
            int n, f, f1, f2, base, probe;
            search_result_t r;
            r = '0;
            r.target = target;
            n = int'(entries_in_use);
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            if (n == 0) return r;
            f2 = 0;
            f1 = 1;
            f  = 1;
            while (f < n) begin
                f2 = f1;
                f1 = f;
                f  = f1 + f2;
            end
            base = -1;
            while (f > 1) begin
                probe = base + f2;
                if (probe > n - 1) probe = n - 1;
                if (probe < 0) probe = 0;
                if (key_table[probe] == target) begin
                    r.found    = 1'b1;
                    r.position = probe[IDX_W-1:0];
                    return r;
                end
                if ($signed(key_table[probe]) < $signed(target)) begin
                    f    = f1;
                    f1   = f2;
                    f2   = f - f1;
                    base = probe;
                end else begin
                    f  = f2;
                    f1 = f1 - f2;
                    f2 = f - f1;
                end
            end
            // last look one past the base
            if (f1 != 0 && base + 1 >= 0 && base + 1 < n
                && key_table[base + 1] == target) begin
                r.found    = 1'b1;
                r.position = 4'(base + 1);
            end
            return r;
        endfunction

        function void note_request(logic req, logic [IDX_W-1:0] idx,
                                   logic [KEY_W-1:0] key);
            search_result_t r;
            if (req == fsst_pkg::REQ_SEARCH) begin
                r = fib_search(key);
                searches++;
                if (r.found) hits++;
                pending.push_back(r);
            end else begin
                key_table[idx] = key;
                writes++;
            end
        endfunction

        function void check_result(logic found, logic [IDX_W-1:0] position);
            search_result_t r;
            if (pending.size() == 0) begin
                report_error($sformatf("result beat with nothing pending: found=%0b position=%0d",
                                       found, position));
                return;
            end
            r = pending.pop_front();
            if (found !== r.found || position !== r.position)
                report_error($sformatf({"search %0d: expected found=%0b position=%0d, ",
                                        "got found=%0b position=%0d"},
                                       $signed(r.target), r.found, r.position,
                                       found, position));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [3:0] entry_index, [35:4] key_value
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [3:0] position
    logic        m_tuser;         // [0] found
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    search_scoreboard sb = new();

    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned n_items = 0;
    int unsigned cycle_count = 0;
    bit [31:0]   counts_seen = '0;

    logic [KEY_W-1:0] seed_keys [TABLE_DEPTH] = '{
        32'h8000_0000, 32'h8000_0001, -65536, -257, -2, -1, 0, 1,
        2, 3, 100, 4096, 65535, 32'h4000_0000, 32'h7fff_fffe, 32'h7fff_ffff
    };
    int count_order [14] = '{13, 16, 0, 31, 1, 2, 3, 5, 8, 4, 7, 12, 17, 6};

    fibonacci_search_sorted_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d searches still pending",
                     cycle_count, sb.pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // results are checked before the same edge's request is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata[IDX_W-1:0]);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[IDX_W-1:0], s_tdata[IDX_W +: KEY_W]);
        end
    end

    // result side: random stalls counted from the waiting beat, one long hold-off
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = rx_idle ? $urandom_range(0, 17) : 0;
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic set_entry_count(input int value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {fsst_pkg::REG_ENTRIES, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.entries_in_use = value[CNT_W-1:0];
        counts_seen[value[CNT_W-1:0]] = 1'b1;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== 32'(value))
            sb.report_error($sformatf("entry count read back %0h, expected %0h",
                                      readback, value));
    endtask

    task automatic send_request(input logic req, input logic [IDX_W-1:0] idx,
                                input logic [KEY_W-1:0] key);
        int gap;
        gap = tx_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, key, idx};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        n_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // sorted with a wide spread, sorted in a narrow band with repeats, or unordered
    task automatic fill_table(input int mode);
        logic [KEY_W-1:0] keys [TABLE_DEPTH];
        longint v;
        v = longint'($signed($urandom));
        if (v > 64'sd2147483583) v -= 64;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (mode)
                0: begin
                    keys[i] = 32'(-64'sd2147483648 + longint'(i) * 268435456
                                  + longint'($urandom_range(0, 268435455)));
                end
                1: begin
                    keys[i] = v[KEY_W-1:0];
                    v += $urandom_range(0, 3);
                end
                default: begin
                    keys[i] = $urandom;
                end
            endcase
        end
        if (mode == 0 && $urandom_range(0, 2) == 0) begin
            keys[0]               = 32'h8000_0000;
            keys[TABLE_DEPTH - 1] = 32'h7fff_ffff;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(fsst_pkg::REQ_WRITE, i[IDX_W-1:0], keys[i]);
    endtask

    // mostly keys that sit in the searched range, some neighbors, some noise
    task automatic search_burst(input int count);
        int lim, pick, e;
        logic [KEY_W-1:0] target;
        lim = (int'(sb.entries_in_use) > TABLE_DEPTH) ? TABLE_DEPTH
                                                       : int'(sb.entries_in_use);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            e = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
            if (pick < 8) begin
                // stray write, may break the ordering
                send_request(fsst_pkg::REQ_WRITE, 4'($urandom), $urandom);
            end else begin
                if (lim > 0 && pick < 70)
                    target = sb.key_table[e];
                else if (lim > 0 && pick < 85)
                    target = pick[0] ? sb.key_table[e] + 1 : sb.key_table[e] - 1;
                else
                    target = $urandom;
                send_request(fsst_pkg::REQ_SEARCH, 4'($urandom), target);
            end
        end
    endtask

    initial begin
        int phase;
        int mode;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, then a fixed table with the key extremes
        set_entry_count(0);
        send_request(fsst_pkg::REQ_SEARCH, 4'hf, 32'h0000_0000);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(fsst_pkg::REQ_WRITE, i[IDX_W-1:0], seed_keys[i]);
        wait_idle();
        set_entry_count(TABLE_DEPTH);
        send_request(fsst_pkg::REQ_SEARCH, 4'h0, 32'h8000_0000);
        send_request(fsst_pkg::REQ_SEARCH, 4'h5, 32'h7fff_ffff);
        send_request(fsst_pkg::REQ_SEARCH, 4'ha, 32'd3);
        send_request(fsst_pkg::REQ_SEARCH, 4'h3, 32'd50);
        wait_idle();
        set_entry_count(31);
        send_request(fsst_pkg::REQ_SEARCH, 4'h0, 32'h4000_0000);
        wait_idle();
        set_entry_count(1);
        send_request(fsst_pkg::REQ_SEARCH, 4'h0, 32'h8000_0000);
        send_request(fsst_pkg::REQ_SEARCH, 4'h0, 32'd1);
        wait_idle();

        phase = 0;
        while (n_items < ITEM_TARGET) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            set_entry_count(phase < 14 ? count_order[phase] : $urandom_range(0, 31));
            if (phase == 0 || $urandom_range(0, 1) == 1) begin
                mode = $urandom_range(0, 99);
                fill_table(mode < 45 ? 0 : (mode < 80 ? 1 : 2));
            end
            if (phase == 1) begin
                // keep offering while the result side holds off
                tx_idle = 1'b0;
                hold_request = 1'b1;
            end
            search_burst($urandom_range(15, 30));
            wait_idle();
            phase++;
        end

        if (sb.pending.size() != 0)
            sb.report_error($sformatf("%0d searches never answered", sb.pending.size()));
        $display("covered %0d searches (%0d found), %0d table writes, %0d count settings",
                 sb.searches, sb.hits, sb.writes, $countones(counts_seen));
        $display("result side held off once for %0d cycles; %0d errors", HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: fibonacci_search_sorted_table_unit.f
sv/fsst_pkg.sv
sv/fsst_key_ram.sv
sv/fibonacci_search_sorted_table_unit.sv
tb/sv/tb.sv
